/* hdl/quaternion_vector_rotate_core_defines.svh */
// assertion macros for the quaternion vector rotation core
// no dependencies; define NO_ASSERTIONS to drop every check
`ifndef QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition that holds on every clock edge outside reset
`define QVR_ASSERT(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define QVR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define QVR_ASSERT(label, clk, rst, expr, msg)
`define QVR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* hdl/qvr_pkg.sv */
// widths, types and codes for the quaternion vector rotation core
// no dependencies
package qvr_pkg;

   localparam int VEC_WIDTH  = 32;
   localparam int QUAT_WIDTH = 32;
   localparam int AXES       = 3;
   localparam int STAGES     = 6;

   // quaternion fraction bits (q2 format)
   localparam int QFRAC   = QUAT_WIDTH - 2;
   // exact and rounded quaternion products
   localparam int QPROD_W = 2 * QUAT_WIDTH;
   localparam int QRND_W  = QUAT_WIDTH + 2;
   // matrix entry, split in two halves for the vector multiply
   localparam int MAT_W   = QUAT_WIDTH + 4;
   localparam int MLO_W   = MAT_W / 2;
   localparam int MHI_W   = MAT_W - MLO_W;
   localparam int PHI_W   = MHI_W + VEC_WIDTH;
   localparam int PLO_W   = MLO_W + 1 + VEC_WIDTH;
   // full entry by component product and the three-term sum
   localparam int TERM_W  = MAT_W + VEC_WIDTH;
   localparam int ACC_W   = TERM_W + 2;
   localparam int RND_W   = ACC_W - QFRAC;

   typedef logic signed [QUAT_WIDTH-1:0] quat_type;
   typedef logic signed [VEC_WIDTH-1:0]  vec_type;
   typedef logic signed [QPROD_W-1:0]    qprod_type;
   typedef logic signed [QRND_W-1:0]     qrnd_type;
   typedef logic signed [MAT_W-1:0]      mat_type;
   typedef logic signed [PHI_W-1:0]      phi_type;
   typedef logic signed [PLO_W-1:0]      plo_type;
   typedef logic signed [TERM_W-1:0]     term_type;
   typedef logic signed [ACC_W-1:0]      acc_type;
   typedef logic signed [RND_W-1:0]      rnd_type;

   localparam qprod_type QPROD_HALF = qprod_type'(1) <<< (QFRAC - 1);
   localparam acc_type   ACC_HALF   = acc_type'(1) <<< (QFRAC - 1);
   localparam mat_type   MAT_ONE    = mat_type'(1) <<< QFRAC;
   localparam vec_type   VEC_MAX    = {1'b0, {(VEC_WIDTH-1){1'b1}}};
   localparam vec_type   VEC_MIN    = {1'b1, {(VEC_WIDTH-1){1'b0}}};

   // direction command
   localparam logic CMD_BODY_TO_EARTH = 1'b0;
   localparam logic CMD_EARTH_TO_BODY = 1'b1;

   // quaternion product slots
   localparam int P_XX   = 0;
   localparam int P_YY   = 1;
   localparam int P_ZZ   = 2;
   localparam int P_XY   = 3;
   localparam int P_XZ   = 4;
   localparam int P_YZ   = 5;
   localparam int P_WX   = 6;
   localparam int P_WY   = 7;
   localparam int P_WZ   = 8;
   localparam int PROD_N = 9;

endpackage

/* hdl/quaternion_vector_rotate_core.sv */
// quaternion rotation of a three-component vector, six-stage pipeline
// throughput one request per cycle while the result side does not stall
// the rate is set by the pipeline: every stage takes a new request each cycle that it may load
// a stalled stage holds, while emptier stages upstream keep filling
// reset clears only the stage valid bits; payload registers are not reset
// depends on qvr_pkg and quaternion_vector_rotate_core_defines.svh
`include "quaternion_vector_rotate_core_defines.svh"

module quaternion_vector_rotate_core
   import qvr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   // request channel
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     req_cmd,
   input  quat_type req_quat_w,
   input  quat_type req_quat_x,
   input  quat_type req_quat_y,
   input  quat_type req_quat_z,
   input  vec_type  req_vec_x,
   input  vec_type  req_vec_y,
   input  vec_type  req_vec_z,
   // result channel
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output vec_type  rsp_out_x,
   output vec_type  rsp_out_y,
   output vec_type  rsp_out_z,
   output logic     rsp_overflow
);

   // ------------------------------------------------------------------
   // pipeline control
   // a stage may load when it is empty or when the stage after it moves;
   // bubbles therefore collapse, and a full pipe with a stalled result side stalls the request side
   // ------------------------------------------------------------------
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] load;

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // ------------------------------------------------------------------
   // stage 1: the nine exact quaternion products, one 32x32 multiply each
   // ------------------------------------------------------------------
   qprod_type prod1_ff [PROD_N];
   qprod_type prod1_in [PROD_N];
   vec_type   vec1_ff  [AXES];
   logic      cmd1_ff;

   always_comb begin
      prod1_in[P_XX] = qprod_type'(req_quat_x) * qprod_type'(req_quat_x);
      prod1_in[P_YY] = qprod_type'(req_quat_y) * qprod_type'(req_quat_y);
      prod1_in[P_ZZ] = qprod_type'(req_quat_z) * qprod_type'(req_quat_z);
      prod1_in[P_XY] = qprod_type'(req_quat_x) * qprod_type'(req_quat_y);
      prod1_in[P_XZ] = qprod_type'(req_quat_x) * qprod_type'(req_quat_z);
      prod1_in[P_YZ] = qprod_type'(req_quat_y) * qprod_type'(req_quat_z);
      prod1_in[P_WX] = qprod_type'(req_quat_w) * qprod_type'(req_quat_x);
      prod1_in[P_WY] = qprod_type'(req_quat_w) * qprod_type'(req_quat_y);
      prod1_in[P_WZ] = qprod_type'(req_quat_w) * qprod_type'(req_quat_z);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         prod1_ff <= prod1_in;
         vec1_ff[0] <= req_vec_x;
         vec1_ff[1] <= req_vec_y;
         vec1_ff[2] <= req_vec_z;
         cmd1_ff <= req_cmd;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: round the products (half up), build the direction-cosine
   // matrix and pick rows or columns according to the command
   // ------------------------------------------------------------------
   qrnd_type rp        [PROD_N];
   mat_type  mat       [AXES][AXES];
   mat_type  row2_in   [AXES][AXES];
   mat_type  row2_ff   [AXES][AXES];
   vec_type  vec2_ff   [AXES];

   always_comb begin
      for (int p = 0; p < PROD_N; p++) begin
         rp[p] = qrnd_type'((prod1_ff[p] + QPROD_HALF) >>> QFRAC);
      end

      mat[0][0] = MAT_ONE - ((mat_type'(rp[P_YY]) + mat_type'(rp[P_ZZ])) <<< 1);
      mat[0][1] = (mat_type'(rp[P_XY]) - mat_type'(rp[P_WZ])) <<< 1;
      mat[0][2] = (mat_type'(rp[P_XZ]) + mat_type'(rp[P_WY])) <<< 1;
      mat[1][0] = (mat_type'(rp[P_XY]) + mat_type'(rp[P_WZ])) <<< 1;
      mat[1][1] = MAT_ONE - ((mat_type'(rp[P_XX]) + mat_type'(rp[P_ZZ])) <<< 1);
      mat[1][2] = (mat_type'(rp[P_YZ]) - mat_type'(rp[P_WX])) <<< 1;
      mat[2][0] = (mat_type'(rp[P_XZ]) - mat_type'(rp[P_WY])) <<< 1;
      mat[2][1] = (mat_type'(rp[P_YZ]) + mat_type'(rp[P_WX])) <<< 1;
      mat[2][2] = MAT_ONE - ((mat_type'(rp[P_XX]) + mat_type'(rp[P_YY])) <<< 1);

      // earth to body uses the transposed matrix
      for (int i = 0; i < AXES; i++) begin
         for (int k = 0; k < AXES; k++) begin
            row2_in[i][k] = (cmd1_ff == CMD_EARTH_TO_BODY) ? mat[k][i] : mat[i][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         row2_ff <= row2_in;
         vec2_ff <= vec1_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: entry by component, split into upper signed and lower
   // unsigned halves of the entry so each multiplier stays narrow
   // ------------------------------------------------------------------
   phi_type phi3_ff [AXES][AXES];
   plo_type plo3_ff [AXES][AXES];
   phi_type phi3_in [AXES][AXES];
   plo_type plo3_in [AXES][AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         for (int k = 0; k < AXES; k++) begin
            phi3_in[i][k] = $signed(row2_ff[i][k][MAT_W-1:MLO_W]) * vec2_ff[k];
            plo3_in[i][k] = $signed({1'b0, row2_ff[i][k][MLO_W-1:0]}) * vec2_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         phi3_ff <= phi3_in;
         plo3_ff <= plo3_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: recombine the halves into exact products
   // ------------------------------------------------------------------
   term_type term4_ff [AXES][AXES];
   term_type term4_in [AXES][AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         for (int k = 0; k < AXES; k++) begin
            term4_in[i][k] = (term_type'(phi3_ff[i][k]) <<< MLO_W)
                           + term_type'(plo3_ff[i][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         term4_ff <= term4_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: dot product per output line, rounding offset folded in
   // ------------------------------------------------------------------
   acc_type acc5_ff [AXES];
   acc_type acc5_in [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         acc5_in[i] = acc_type'(term4_ff[i][0]) + acc_type'(term4_ff[i][1])
                    + acc_type'(term4_ff[i][2]) + ACC_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         acc5_ff <= acc5_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: drop the fraction, saturate to the vector range, flag it;
   // this is the output register
   // ------------------------------------------------------------------
   rnd_type shifted [AXES];
   vec_type out6_in [AXES];
   vec_type out6_ff [AXES];
   logic [AXES-1:0] sat6_in;
   logic            ovf6_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         shifted[i] = acc5_ff[i][ACC_W-1:QFRAC];
         sat6_in[i] = !((&shifted[i][RND_W-1:VEC_WIDTH-1])
                     || !(|shifted[i][RND_W-1:VEC_WIDTH-1]));
         if (!sat6_in[i]) begin
            out6_in[i] = shifted[i][VEC_WIDTH-1:0];
         end else if (shifted[i][RND_W-1]) begin
            out6_in[i] = VEC_MIN;
         end else begin
            out6_in[i] = VEC_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         out6_ff <= out6_in;
         ovf6_ff <= |sat6_in;
      end
   end

   assign rsp_out_x    = out6_ff[0];
   assign rsp_out_y    = out6_ff[1];
   assign rsp_out_z    = out6_ff[2];
   assign rsp_overflow = ovf6_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   // the request side is held off only when every stage is occupied
   `QVR_ASSERT_IMPLY(a_stall_only_when_full, clock, reset, req_stall, &valid_ff, "request stalled with a bubble in the pipe")
   // a stage that cannot move keeps its request
   `QVR_ASSERT_NEXT(a_held_stage_kept, clock, reset, |(valid_ff & ~load), (valid_ff & $past(valid_ff & ~load)) == $past(valid_ff & ~load), "held stage lost its request")
   // overflow means at least one component sits at a range limit
   `QVR_ASSERT_IMPLY(a_overflow_saturated, clock, reset, rsp_valid && rsp_overflow, rsp_out_x == VEC_MAX || rsp_out_x == VEC_MIN || rsp_out_y == VEC_MAX || rsp_out_y == VEC_MIN || rsp_out_z == VEC_MAX || rsp_out_z == VEC_MIN, "overflow without a saturated component")

endmodule

/* tb/sv/quaternion_rotation_check.sv */
// request/result watcher for the quaternion vector rotation core: predicts each
// rotated vector from the accepted request and compares it with the result channel
// depends on qvr_pkg
`timescale 1ns / 100ps

module quaternion_rotation_check
   import qvr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_stall,
   input  logic     req_cmd,
   input  quat_type req_quat_w,
   input  quat_type req_quat_x,
   input  quat_type req_quat_y,
   input  quat_type req_quat_z,
   input  vec_type  req_vec_x,
   input  vec_type  req_vec_y,
   input  vec_type  req_vec_z,
   input  logic     rsp_valid,
   input  logic     rsp_stall,
   input  vec_type  rsp_out_x,
   input  vec_type  rsp_out_y,
   input  vec_type  rsp_out_z,
   input  logic     rsp_overflow,
   output int       mismatches,
   output int       outstanding
);

   typedef logic signed [79:0] wide_type;

   typedef struct packed {
      vec_type x;
      vec_type y;
      vec_type z;
      logic    overflow;
   } rotation_type;

   rotation_type rotations_due[$];
   int           fail_total;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      fail_total  = 0;
   end

   // exact product of two q2.30 parts, rounded half up back to 30 fraction bits
   function automatic longint rounded_quat_product(quat_type a, quat_type b);
      longint p;
      p = longint'(a) * longint'(b);
      return (p + (longint'(1) << (QFRAC - 1))) >>> QFRAC;
   endfunction

   function automatic rotation_type rotate_vector(logic cmd, quat_type qw, quat_type qx,
                                                  quat_type qy, quat_type qz, vec_type vx,
                                                  vec_type vy, vec_type vz);
      longint       p [PROD_N];
      longint       dcm [3][3];
      longint       one;
      longint       coef;
      vec_type      v [3];
      vec_type      comp [3];
      wide_type     acc;
      wide_type     rnd;
      rotation_type r;
      one      = longint'(1) << QFRAC;
      v[0]     = vx;
      v[1]     = vy;
      v[2]     = vz;
      p[P_XX]  = rounded_quat_product(qx, qx);
      p[P_YY]  = rounded_quat_product(qy, qy);
      p[P_ZZ]  = rounded_quat_product(qz, qz);
      p[P_XY]  = rounded_quat_product(qx, qy);
      p[P_XZ]  = rounded_quat_product(qx, qz);
      p[P_YZ]  = rounded_quat_product(qy, qz);
      p[P_WX]  = rounded_quat_product(qw, qx);
      p[P_WY]  = rounded_quat_product(qw, qy);
      p[P_WZ]  = rounded_quat_product(qw, qz);
      dcm[0][0] = one - 2 * (p[P_YY] + p[P_ZZ]);
      dcm[0][1] = 2 * (p[P_XY] - p[P_WZ]);
      dcm[0][2] = 2 * (p[P_XZ] + p[P_WY]);
      dcm[1][0] = 2 * (p[P_XY] + p[P_WZ]);
      dcm[1][1] = one - 2 * (p[P_XX] + p[P_ZZ]);
      dcm[1][2] = 2 * (p[P_YZ] - p[P_WX]);
      dcm[2][0] = 2 * (p[P_XZ] - p[P_WY]);
      dcm[2][1] = 2 * (p[P_YZ] + p[P_WX]);
      dcm[2][2] = one - 2 * (p[P_XX] + p[P_YY]);
      r.overflow = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = '0;
         for (int k = 0; k < 3; k++) begin
            // earth to body uses the transposed matrix
            coef = (cmd == CMD_EARTH_TO_BODY) ? dcm[k][i] : dcm[i][k];
            acc  = acc + wide_type'(coef) * wide_type'(v[k]);
         end
         rnd = (acc + (wide_type'(1) << (QFRAC - 1))) >>> QFRAC;
         if (rnd > wide_type'(VEC_MAX)) begin
            comp[i]    = VEC_MAX;
            r.overflow = 1'b1;
         end else if (rnd < wide_type'(VEC_MIN)) begin
            comp[i]    = VEC_MIN;
            r.overflow = 1'b1;
         end else begin
            comp[i] = vec_type'(rnd);
         end
      end
      r.x = comp[0];
      r.y = comp[1];
      r.z = comp[2];
      return r;
   endfunction

   always @(posedge clock) begin
      rotation_type due;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (rotations_due.size() == 0) begin
               $error("result with no request outstanding: x=%0d y=%0d z=%0d overflow=%0b",
                      rsp_out_x, rsp_out_y, rsp_out_z, rsp_overflow);
               fail_total++;
            end else begin
               due = rotations_due.pop_front();
               if (rsp_out_x !== due.x) begin
                  $error("out_x mismatch: expected %0d, actual %0d", due.x, rsp_out_x);
                  fail_total++;
               end
               if (rsp_out_y !== due.y) begin
                  $error("out_y mismatch: expected %0d, actual %0d", due.y, rsp_out_y);
                  fail_total++;
               end
               if (rsp_out_z !== due.z) begin
                  $error("out_z mismatch: expected %0d, actual %0d", due.z, rsp_out_z);
                  fail_total++;
               end
               if (rsp_overflow !== due.overflow) begin
                  $error("overflow mismatch: expected %0b, actual %0b",
                         due.overflow, rsp_overflow);
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall)
            rotations_due.push_back(rotate_vector(req_cmd, req_quat_w, req_quat_x,
                                                  req_quat_y, req_quat_z, req_vec_x,
                                                  req_vec_y, req_vec_z));
      end
      mismatches  <= fail_total;
      outstanding <= rotations_due.size();
   end

endmodule

/* tb/sv/tb_quaternion_vector_rotate_core.sv */
// top of the quaternion vector rotation testbench: clock, reset, request stimulus,
// result-side stall pattern and the verdict
// depends on qvr_pkg, quaternion_vector_rotate_core and quaternion_rotation_check
`timescale 1ns / 100ps

module tb_quaternion_vector_rotate_core
   import qvr_pkg::*;
();

   localparam int RANDOM_REQUESTS = 1400;
   // worst case is far below this: long gaps, heavy stall and two hold-offs
   localparam int CYCLE_LIMIT     = 200000;
   // settle time after the last result
   localparam int DRAIN_CYCLES    = 24;

   // q2.30 and q16.16 constants for the directed requests
   localparam quat_type Q_ONE    = 32'sh4000_0000;
   localparam quat_type Q_NEG1   = -32'sh4000_0000;
   localparam quat_type Q_COS45  = 32'sd759250125;
   localparam vec_type  V_ONE    = 32'sh0001_0000;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   logic     req_cmd;
   quat_type req_quat_w;
   quat_type req_quat_x;
   quat_type req_quat_y;
   quat_type req_quat_z;
   vec_type  req_vec_x;
   vec_type  req_vec_y;
   vec_type  req_vec_z;
   logic     rsp_valid;
   logic     rsp_stall;
   vec_type  rsp_out_x;
   vec_type  rsp_out_y;
   vec_type  rsp_out_z;
   logic     rsp_overflow;

   int       mismatches;
   int       outstanding;
   int       cycle_count;

   quaternion_vector_rotate_core dut (.*);

   // watches both channels, predicts every rotation and counts mismatches
   quaternion_rotation_check rotation_check (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run guard: a stuck handshake or a lost result ends here
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_quaternion_vector_rotate_core failed");
         $finish;
      end
   end

   // offer one request from the falling edge and hold it until a rising edge takes it
   task automatic drive_request(logic cmd, quat_type qw, quat_type qx, quat_type qy,
                                quat_type qz, vec_type vx, vec_type vy, vec_type vz);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_quat_w <= qw;
      req_quat_x <= qx;
      req_quat_y <= qy;
      req_quat_z <= qz;
      req_vec_x  <= vx;
      req_vec_y  <= vy;
      req_vec_z  <= vz;
      do @(posedge clock); while (req_stall);
   endtask

   // quaternion part: full-range noise, roughly unit-sized values, or a corner value
   function automatic quat_type pick_quat_part();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 3)
         return quat_type'($urandom);
      if (sel < 8)
         return quat_type'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return Q_ONE;
         2: return Q_NEG1;
         3: return Q_COS45;
         4: return VEC_MAX;
         default: return VEC_MIN;
      endcase
   endfunction

   // vector part: mostly moderate magnitudes so the rounding path is checked,
   // some full-range values and extremes to drive saturation
   function automatic vec_type pick_vec_part();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5)
         return vec_type'(int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
      if (sel < 8)
         return vec_type'($urandom);
      case ($urandom_range(0, 3))
         0: return VEC_MAX;
         1: return VEC_MIN;
         2: return '0;
         default: return -V_ONE;
      endcase
   endfunction

   // result side: stretches of free flow, light and heavy stalling, and twice a
   // long hold-off so the pipeline fills and pushes back on the request side
   initial begin
      int stretch;
      int span;
      int stall_pct;
      rsp_stall = 1'b0;
      stretch   = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stretch++;
         if (stretch == 4 || stretch == 12) begin
            span = $urandom_range(60, 120);
            repeat (span) @(negedge clock) rsp_stall <= 1'b1;
         end else begin
            span = $urandom_range(20, 200);
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 30;
               default: stall_pct = 70;
            endcase
            repeat (span) @(negedge clock) rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // request side and verdict
   initial begin
      int burst_left;
      int gap;
      req_valid  = 1'b0;
      req_cmd    = CMD_BODY_TO_EARTH;
      req_quat_w = '0;
      req_quat_x = '0;
      req_quat_y = '0;
      req_quat_z = '0;
      req_vec_x  = '0;
      req_vec_y  = '0;
      req_vec_z  = '0;
      reset      = 1'b1;
      burst_left = 0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // identity quaternion in both directions: vector passes straight through
      drive_request(CMD_BODY_TO_EARTH, Q_ONE, '0, '0, '0, V_ONE, 2 * V_ONE, -3 * V_ONE);
      drive_request(CMD_EARTH_TO_BODY, Q_ONE, '0, '0, '0, V_ONE, 2 * V_ONE, -3 * V_ONE);
      // zero quaternion gives the identity matrix as well, at the vector extremes
      drive_request(CMD_BODY_TO_EARTH, '0, '0, '0, '0, VEC_MAX, VEC_MIN, VEC_MAX);
      drive_request(CMD_EARTH_TO_BODY, '0, '0, '0, '0, VEC_MIN, VEC_MAX, VEC_MIN);
      // quarter turns about each axis, forward and inverse
      drive_request(CMD_BODY_TO_EARTH, Q_COS45, Q_COS45, '0, '0, V_ONE, V_ONE, V_ONE);
      drive_request(CMD_EARTH_TO_BODY, Q_COS45, Q_COS45, '0, '0, V_ONE, V_ONE, V_ONE);
      drive_request(CMD_BODY_TO_EARTH, Q_COS45, '0, Q_COS45, '0, V_ONE, -V_ONE, V_ONE);
      drive_request(CMD_EARTH_TO_BODY, Q_COS45, '0, Q_COS45, '0, V_ONE, -V_ONE, V_ONE);
      drive_request(CMD_BODY_TO_EARTH, Q_COS45, '0, '0, Q_COS45, 5 * V_ONE, '0, -V_ONE);
      drive_request(CMD_EARTH_TO_BODY, Q_COS45, '0, '0, Q_COS45, 5 * V_ONE, '0, -V_ONE);
      // half turns about z and about x at the vector extremes: negating the minimum saturates
      drive_request(CMD_BODY_TO_EARTH, '0, '0, '0, Q_ONE, VEC_MAX, VEC_MIN, VEC_MAX);
      drive_request(CMD_EARTH_TO_BODY, '0, Q_NEG1, '0, '0, VEC_MIN, VEC_MIN, VEC_MIN);
      // non-unit quaternions: scaled and sheared matrices, saturation both ways
      drive_request(CMD_BODY_TO_EARTH, VEC_MAX, VEC_MAX, VEC_MAX, VEC_MAX,
                    VEC_MAX, VEC_MAX, VEC_MAX);
      drive_request(CMD_EARTH_TO_BODY, VEC_MIN, VEC_MIN, VEC_MIN, VEC_MIN,
                    VEC_MIN, VEC_MIN, VEC_MIN);
      drive_request(CMD_BODY_TO_EARTH, VEC_MIN, VEC_MAX, VEC_MIN, VEC_MAX,
                    VEC_MIN, VEC_MAX, VEC_MIN);
      drive_request(CMD_EARTH_TO_BODY, VEC_MAX, VEC_MIN, VEC_MAX, VEC_MIN,
                    VEC_MAX, VEC_MIN, VEC_MAX);
      // large quaternion on a zero vector, and smallest steps around zero
      drive_request(CMD_BODY_TO_EARTH, VEC_MAX, VEC_MIN, VEC_MAX, VEC_MIN, '0, '0, '0);
      drive_request(CMD_EARTH_TO_BODY, Q_COS45, '0, Q_COS45, '0, 32'sd1, -32'sd1, '0);
      drive_request(CMD_BODY_TO_EARTH, 32'sd1, -32'sd1, 32'sd1, -32'sd1,
                    -32'sd1, 32'sd1, -32'sd1);

      // random requests in bursts with random gaps, some bursts straight on
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               @(negedge clock) req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         burst_left--;
         drive_request(logic'($urandom_range(0, 1)), pick_quat_part(), pick_quat_part(),
                       pick_quat_part(), pick_quat_part(), pick_vec_part(),
                       pick_vec_part(), pick_vec_part());
      end
      @(negedge clock) req_valid <= 1'b0;

      // drain: every predicted result must arrive, then watch a little longer
      // for anything unexpected
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("tb_quaternion_vector_rotate_core passed");
      else
         $display("tb_quaternion_vector_rotate_core failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/qvr_pkg.sv
hdl/quaternion_vector_rotate_core.sv
tb/sv/quaternion_rotation_check.sv
tb/sv/tb_quaternion_vector_rotate_core.sv
